// File: rtl/pdl_pkg.sv
// Package for the pooled doubly linked pending list unit.
// Holds pool sizing constants, command and status codes, and the payload structs.
// No dependencies.
`timescale 1ns / 1ps

package pdl_pkg;

  // Pool sizing; a link value of PoolNodes marks "no node"
  localparam int unsigned PoolNodes = 1024;
  localparam int unsigned NodeBits  = $clog2(PoolNodes);
  localparam int unsigned LinkBits  = NodeBits + 1;
  localparam int unsigned TagBits   = 32;
  localparam int unsigned CountBits = LinkBits;

  localparam logic [LinkBits-1:0] NoneIdx = LinkBits'(PoolNodes);

  typedef enum logic [1:0] {
    CMD_ENQUEUE      = 2'd0,
    CMD_REMOVE       = 2'd1,
    CMD_CURSOR_RESET = 2'd2,
    CMD_CURSOR_STEP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_BAD_REMOVE = 2'd2,
    ST_END        = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [TagBits-1:0]  tag_in;
    logic [NodeBits-1:0] node_in;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [NodeBits-1:0]  node_out;
    logic [TagBits-1:0]   tag_out;
    logic [CountBits-1:0] count;
    logic                 is_empty;
  } result_t;

  // One entry of the link memory
  typedef struct packed {
    logic [LinkBits-1:0] nxt;
    logic [LinkBits-1:0] prv;
  } link_t;

  // One entry of the data memory: membership flag and tag
  typedef struct packed {
    logic               in_list;
    logic [TagBits-1:0] tag;
  } data_t;

endpackage

// File: rtl/pooled_doubly_linked_pending_list_unit.sv
// Sequencing: cursor reset, pool exhausted, step at end and removal of the cursor node or of a
// never-used node give a registered result from idle; enqueue, cursor step and removal of an
// unlisted node run S_ENQ, S_STEP or S_REM; a valid removal runs S_REM, S_REM_PV and S_REM_N
// (up to three link writes). Throughput: one command at a time; busy_o is high until the result
// strobe, and the next command is taken in the cycle the result is shown. The receiver cannot stall.
// Reset: control registers clear at once; no clearing pass, a fresh-node count stands in.
`timescale 1ns / 1ps

module pooled_doubly_linked_pending_list_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pdl_pkg::cmd_t    cmd_i,
  output logic             busy_o,
  output logic             done_o,
  output pdl_pkg::result_t res_o
);

  localparam int unsigned NB = pdl_pkg::NodeBits;
  localparam int unsigned LB = pdl_pkg::LinkBits;

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ENQ    = 3'd1;
  localparam logic [2:0] S_REM    = 3'd2;
  localparam logic [2:0] S_REM_PV = 3'd3;
  localparam logic [2:0] S_REM_N  = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;

  logic [2:0] state_q, state_d;

  // List and free-list registers
  logic [LB-1:0] head_q, head_d;
  logic [LB-1:0] tail_q, tail_d;
  logic [LB-1:0] cursor_q, cursor_d;
  logic [LB-1:0] free_head_q, free_head_d;
  logic [LB-1:0] fresh_q, fresh_d;   // nodes at or above this were never allocated
  logic [pdl_pkg::CountBits-1:0] count_q, count_d;

  // Latched command and removal neighbors
  logic [pdl_pkg::TagBits-1:0] tag_q, tag_d;
  logic [NB-1:0] node_q, node_d;
  logic [LB-1:0] nx_q, nx_d;
  logic [LB-1:0] pv_q, pv_d;

  logic             done_q, done_d;
  pdl_pkg::result_t res_q, res_d;

  // Memory ports
  pdl_pkg::link_t link_mem [pdl_pkg::PoolNodes];
  pdl_pkg::data_t data_mem [pdl_pkg::PoolNodes];
  logic [NB-1:0]  lk_wa, lk_ra, dt_wa, dt_ra;
  logic           lk_we_nxt, lk_we_prv, dt_we;
  pdl_pkg::link_t lk_wd, lk_rd_q;
  pdl_pkg::data_t dt_wd, dt_rd_q;

  function automatic logic [pdl_pkg::CountBits-1:0] CountBitsOne();
    return pdl_pkg::CountBits'(1);
  endfunction

  // Link memory: next and previous fields written separately, registered read
  always_ff @(posedge clk_i) begin
    if (lk_we_nxt) link_mem[lk_wa].nxt <= lk_wd.nxt;
    if (lk_we_prv) link_mem[lk_wa].prv <= lk_wd.prv;
    lk_rd_q <= link_mem[lk_ra];
  end

  // Data memory: tag and membership, registered read
  always_ff @(posedge clk_i) begin
    if (dt_we) data_mem[dt_wa] <= dt_wd;
    dt_rd_q <= data_mem[dt_ra];
  end

  // Sequencer and datapath
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cursor_d    = cursor_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    count_d     = count_q;
    tag_d       = tag_q;
    node_d      = node_q;
    nx_d        = nx_q;
    pv_d        = pv_q;
    done_d      = 1'b0;
    res_d       = res_q;

    lk_wa     = tail_q[NB-1:0];
    lk_ra     = free_head_q[NB-1:0];
    lk_we_nxt = 1'b0;
    lk_we_prv = 1'b0;
    lk_wd     = '{nxt: free_head_q, prv: tail_q};
    dt_wa     = node_q;
    dt_ra     = free_head_q[NB-1:0];
    dt_we     = 1'b0;
    dt_wd     = '{in_list: 1'b0, tag: '0};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          tag_d  = cmd_i.tag_in;
          node_d = cmd_i.node_in;
          case (cmd_i.cmd)
            pdl_pkg::CMD_ENQUEUE: begin
              if (free_head_q == pdl_pkg::NoneIdx) begin
                done_d = 1'b1;
                res_d  = '{status: pdl_pkg::ST_EXHAUSTED, node_out: '0, tag_out: '0,
                           count: count_q, is_empty: (count_q == '0)};
              end else begin
                // link the old tail to the new node now, fetch the free link
                lk_we_nxt = (tail_q != pdl_pkg::NoneIdx);
                lk_ra     = free_head_q[NB-1:0];
                state_d   = S_ENQ;
              end
            end
            pdl_pkg::CMD_REMOVE: begin
              lk_ra = cmd_i.node_in;
              dt_ra = cmd_i.node_in;
              if (({1'b0, cmd_i.node_in} >= fresh_q) ||
                  ({1'b0, cmd_i.node_in} == cursor_q)) begin
                done_d = 1'b1;
                res_d  = '{status: pdl_pkg::ST_BAD_REMOVE, node_out: '0, tag_out: '0,
                           count: count_q, is_empty: (count_q == '0)};
              end else begin
                state_d = S_REM;
              end
            end
            pdl_pkg::CMD_CURSOR_RESET: begin
              cursor_d = head_q;
              done_d   = 1'b1;
              res_d    = '{status: pdl_pkg::ST_OK, node_out: '0, tag_out: '0,
                           count: count_q, is_empty: (count_q == '0)};
            end
            pdl_pkg::CMD_CURSOR_STEP: begin
              lk_ra = cursor_q[NB-1:0];
              dt_ra = cursor_q[NB-1:0];
              if (cursor_q == pdl_pkg::NoneIdx) begin
                done_d = 1'b1;
                res_d  = '{status: pdl_pkg::ST_END, node_out: '0, tag_out: '0,
                           count: count_q, is_empty: (count_q == '0)};
              end else begin
                state_d = S_STEP;
              end
            end
            default: ;
          endcase
        end
      end

      // Pop the free list, write the new tail node
      S_ENQ: begin
        if (free_head_q == fresh_q) begin
          free_head_d = free_head_q + LB'(1);
          fresh_d     = fresh_q + LB'(1);
        end else begin
          free_head_d = lk_rd_q.nxt;
        end
        lk_wa     = free_head_q[NB-1:0];
        lk_we_nxt = 1'b1;
        lk_we_prv = 1'b1;
        lk_wd     = '{nxt: pdl_pkg::NoneIdx, prv: tail_q};
        dt_wa     = free_head_q[NB-1:0];
        dt_we     = 1'b1;
        dt_wd     = '{in_list: 1'b1, tag: tag_q};
        if (tail_q == pdl_pkg::NoneIdx) head_d = free_head_q;
        tail_d  = free_head_q;
        count_d = count_q + CountBitsOne();
        done_d  = 1'b1;
        res_d   = '{status: pdl_pkg::ST_OK, node_out: free_head_q[NB-1:0], tag_out: '0,
                    count: count_d, is_empty: 1'b0};
        state_d = S_IDLE;
      end

      // Check membership, fix the successor's back link
      S_REM: begin
        if (!dt_rd_q.in_list) begin
          done_d  = 1'b1;
          res_d   = '{status: pdl_pkg::ST_BAD_REMOVE, node_out: '0, tag_out: '0,
                      count: count_q, is_empty: (count_q == '0)};
          state_d = S_IDLE;
        end else begin
          nx_d  = lk_rd_q.nxt;
          pv_d  = lk_rd_q.prv;
          lk_wa = lk_rd_q.nxt[NB-1:0];
          lk_wd = '{nxt: lk_rd_q.nxt, prv: lk_rd_q.prv};
          if (lk_rd_q.nxt == pdl_pkg::NoneIdx) tail_d = lk_rd_q.prv;
          else lk_we_prv = 1'b1;
          dt_wa   = node_q;
          dt_we   = 1'b1;
          dt_wd   = '{in_list: 1'b0, tag: '0};
          state_d = S_REM_PV;
        end
      end

      // Fix the predecessor's forward link
      S_REM_PV: begin
        lk_wa = pv_q[NB-1:0];
        lk_wd = '{nxt: nx_q, prv: pv_q};
        if (pv_q == pdl_pkg::NoneIdx) head_d = nx_q;
        else lk_we_nxt = 1'b1;
        state_d = S_REM_N;
      end

      // Push the node onto the free list
      S_REM_N: begin
        lk_wa       = node_q;
        lk_we_nxt   = 1'b1;
        lk_wd       = '{nxt: free_head_q, prv: pv_q};
        free_head_d = {1'b0, node_q};
        count_d     = count_q - CountBitsOne();
        done_d      = 1'b1;
        res_d       = '{status: pdl_pkg::ST_OK, node_out: '0, tag_out: '0,
                        count: count_d, is_empty: (count_d == '0)};
        state_d     = S_IDLE;
      end

      // Return the cursor node and advance
      S_STEP: begin
        cursor_d = lk_rd_q.nxt;
        done_d   = 1'b1;
        res_d    = '{status: pdl_pkg::ST_OK, node_out: cursor_q[NB-1:0],
                     tag_out: dt_rd_q.tag, count: count_q, is_empty: (count_q == '0)};
        state_d  = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= pdl_pkg::NoneIdx;
      tail_q      <= pdl_pkg::NoneIdx;
      cursor_q    <= pdl_pkg::NoneIdx;
      free_head_q <= '0;
      fresh_q     <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cursor_q    <= cursor_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
      done_q      <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    node_q <= node_d;
    nx_q   <= nx_d;
    pv_q   <= pv_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/pdl_checker.sv
// Port-level checker for the pooled doubly linked pending list unit, with its bind.
// Depends on pdl_pkg.
`timescale 1ns / 1ps

module pdl_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input pdl_pkg::cmd_t    cmd_i,
  input logic             busy_o,
  input logic             done_o,
  input pdl_pkg::result_t res_o
);

  // Empty flag tracks the count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.is_empty == (res_o.count == '0)))
    else $error("is_empty disagrees with count");

  // Failed commands carry no node and no tag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != pdl_pkg::ST_OK) |-> (res_o.node_out == '0 && res_o.tag_out == '0))
    else $error("error result with nonzero node or tag");

  // The pool runs dry only when every node is listed
  a_exhausted_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == pdl_pkg::ST_EXHAUSTED) |->
      (res_o.count == pdl_pkg::CountBits'(pdl_pkg::PoolNodes)))
    else $error("pool exhausted with free nodes left");

  // Cursor reset answers in the next cycle with status ok
  a_cursor_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.cmd == pdl_pkg::CMD_CURSOR_RESET) |=>
      (done_o && res_o.status == pdl_pkg::ST_OK && !busy_o))
    else $error("cursor reset result missing");

endmodule

bind pooled_doubly_linked_pending_list_unit pdl_checker u_pdl_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .cmd_i   (cmd_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
